// ===== rtl/dbr_pkg.sv =====
// ----------------------------------------------------------------------------
// dbr_pkg
// Shared types, constants and helpers for the de Bruijn next-hop router.
// ----------------------------------------------------------------------------
package dbr_pkg;

    localparam int ID_W      = 16;
    localparam int SHIFT_W   = 5;   // holds a shift of 0..ID_W plus one digit
    localparam int LOG_W     = 4;
    localparam int CFG_IDX_W = 1;

    // log2 thresholds that select a digit of 2 and of 4 bits
    localparam int LG_DIGIT2_MIN = 3;
    localparam int LG_DIGIT4_MIN = 7;

    typedef logic [ID_W-1:0]    id_t;
    typedef logic [SHIFT_W-1:0] shift_t;
    typedef logic [LOG_W-1:0]   log_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SELF_ID    = 1'b0,
        CFG_NODE_COUNT = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic load;
        logic scan_step;
        logic hop_calc;
        logic emit_self;
        logic emit_hop;
    } dbr_cmd_t;

    typedef struct packed {
        logic eq_self;
        logic match;
        logic zero_shift;
        logic scan_end;
    } dbr_status_t;

    // Priority encoder: index of the highest set bit, zero for zero
    function automatic log_t floor_log2(id_t v);
        log_t r;
        r = '0;
        for (int k = 1; k < ID_W; k++) begin
            if (v[k]) begin
                r = LOG_W'(k);
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/dbr_datapath.sv =====
// ----------------------------------------------------------------------------
// dbr_datapath
// Configuration registers, overlay geometry, shift-match unit and hop logic.
// ----------------------------------------------------------------------------
module dbr_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [dbr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  dbr_pkg::id_t                 cfg_data,
    input  dbr_pkg::id_t                 target_id,
    input  dbr_pkg::dbr_cmd_t            cmd,
    output dbr_pkg::dbr_status_t         status,
    output dbr_pkg::id_t                 hop_id,
    output logic                         is_self,
    output logic                         used_fallback,
    output logic                         done
);

    dbr_pkg::id_t    self_reg,  self_next;
    dbr_pkg::id_t    count_reg, count_next;
    dbr_pkg::id_t    t_reg,     t_next;
    dbr_pkg::shift_t i_reg,     i_next;
    dbr_pkg::shift_t p_reg,     p_next;
    dbr_pkg::shift_t w_reg,     w_next;
    dbr_pkg::id_t    mask_reg,  mask_next;
    dbr_pkg::id_t    hop_reg,   hop_next;
    dbr_pkg::id_t    out_hop_reg, out_hop_next;
    logic            is_self_reg, is_self_next;
    logic            fb_reg,    fb_next;
    logic            done_reg,  done_next;

    dbr_pkg::log_t   lg;
    dbr_pkg::shift_t p_val;
    dbr_pkg::shift_t w_val;
    logic [dbr_pkg::ID_W:0] mask_wide;

    dbr_pkg::id_t    shifted_self;
    dbr_pkg::id_t    scan_mask;
    dbr_pkg::shift_t i_sum;
    logic [2*dbr_pkg::ID_W-1:0] hop_wide;

    // Geometry of the overlay from the node count
    always_comb
    begin
        lg = dbr_pkg::floor_log2(count_reg);
        if (lg < dbr_pkg::LOG_W'(dbr_pkg::LG_DIGIT2_MIN)) begin
            p_val = dbr_pkg::SHIFT_W'(1);
        end else if (lg < dbr_pkg::LOG_W'(dbr_pkg::LG_DIGIT4_MIN)) begin
            p_val = dbr_pkg::SHIFT_W'(2);
        end else begin
            p_val = dbr_pkg::SHIFT_W'(4);
        end
        w_val     = (dbr_pkg::SHIFT_W'(lg) + p_val) & ~(p_val - dbr_pkg::SHIFT_W'(1));
        mask_wide = (dbr_pkg::ID_W+1)'(1) << w_val;
        mask_wide = mask_wide - (dbr_pkg::ID_W+1)'(1);
    end

    // Compare target against self shifted up by the current shift amount
    always_comb
    begin
        shifted_self = dbr_pkg::ID_W'(self_reg << i_reg);
        scan_mask    = mask_reg & dbr_pkg::ID_W'({dbr_pkg::ID_W{1'b1}} << i_reg);
        i_sum        = i_reg + p_reg;
        hop_wide     = ({{dbr_pkg::ID_W{1'b0}}, self_reg} << i_reg)
                     | {{dbr_pkg::ID_W{1'b0}}, t_reg};
        hop_wide     = hop_wide >> (i_reg - p_reg);
    end

    assign status.eq_self    = (t_reg == self_reg);
    assign status.match      = (((shifted_self ^ t_reg) & scan_mask) == '0);
    assign status.zero_shift = (i_reg == '0);
    assign status.scan_end   = (i_sum >= w_reg);

    always_comb
    begin
        self_next    = self_reg;
        count_next   = count_reg;
        t_next       = t_reg;
        i_next       = i_reg;
        p_next       = p_reg;
        w_next       = w_reg;
        mask_next    = mask_reg;
        hop_next     = hop_reg;
        out_hop_next = out_hop_reg;
        is_self_next = is_self_reg;
        fb_next      = fb_reg;
        done_next    = cmd.emit_self | cmd.emit_hop;

        if (cfg_valid && cfg_ready) begin
            unique case (dbr_pkg::cfg_idx_t'(cfg_index))
                dbr_pkg::CFG_SELF_ID:    self_next  = cfg_data;
                dbr_pkg::CFG_NODE_COUNT: count_next = cfg_data;
                default: ;
            endcase
        end

        if (cmd.load) begin
            t_next    = target_id;
            i_next    = '0;
            p_next    = p_val;
            w_next    = w_val;
            mask_next = dbr_pkg::ID_W'(mask_wide);
        end

        if (cmd.scan_step) begin
            i_next = i_sum;
        end

        if (cmd.hop_calc) begin
            hop_next = dbr_pkg::ID_W'(hop_wide) & mask_reg;
        end

        if (cmd.emit_self) begin
            out_hop_next = self_reg;
            is_self_next = status.eq_self;
            fb_next      = 1'b0;
        end

        // Drop the top digit when the hop is outside the overlay
        if (cmd.emit_hop) begin
            is_self_next = 1'b0;
            if (hop_reg >= count_reg) begin
                out_hop_next = hop_reg & (mask_reg >> p_reg);
                fb_next      = 1'b1;
            end else begin
                out_hop_next = hop_reg;
                fb_next      = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            self_reg  <= '0;
            count_reg <= dbr_pkg::ID_W'(1);
            done_reg  <= 1'b0;
        end else begin
            self_reg  <= self_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg       <= t_next;
        i_reg       <= i_next;
        p_reg       <= p_next;
        w_reg       <= w_next;
        mask_reg    <= mask_next;
        hop_reg     <= hop_next;
        out_hop_reg <= out_hop_next;
        is_self_reg <= is_self_next;
        fb_reg      <= fb_next;
    end

    assign hop_id        = out_hop_reg;
    assign is_self       = is_self_reg;
    assign used_fallback = fb_reg;
    assign done          = done_reg;

endmodule

// ===== rtl/dbr_ctrl.sv =====
// ----------------------------------------------------------------------------
// dbr_ctrl
// Sequencer: load, self check, digit-shift scan, hop build and result issue.
// ----------------------------------------------------------------------------
module dbr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  dbr_pkg::dbr_status_t status,
    output dbr_pkg::dbr_cmd_t    cmd,
    output logic                 busy
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SCAN,
        ST_HOP,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                if (status.eq_self) begin
                    cmd.emit_self = 1'b1;
                    state_next    = ST_IDLE;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.match) begin
                    // match with no shift: target only differs outside the mask
                    if (status.zero_shift) begin
                        cmd.emit_self = 1'b1;
                        state_next    = ST_IDLE;
                    end else begin
                        state_next = ST_HOP;
                    end
                end else begin
                    cmd.scan_step = 1'b1;
                    if (status.scan_end) begin
                        state_next = ST_HOP;
                    end
                end
            end
            ST_HOP:
            begin
                cmd.hop_calc = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.emit_hop = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ===== rtl/debruijn_next_hop_router.sv =====
// ----------------------------------------------------------------------------
// debruijn_next_hop_router
// Next-hop lookup for a de Bruijn overlay seen from this node.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; the result shows on
// hop_id, is_self and used_fallback for exactly one cycle with done high,
// and the receiver cannot stall it. A target equal to this node returns
// after the self check, and a match at shift zero after the first compare.
// Otherwise one shared compare unit checks one digit shift per cycle, then
// the hop is built and issued; the number of shifts tried is 1 up to 4,
// as the id width holds at most four digits; busy drops as done rises.
// Write self_id and node_count over the cfg channel only while busy is low.
// ----------------------------------------------------------------------------
module debruijn_next_hop_router (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [dbr_pkg::ID_W-1:0]      target_id,
    output logic                          done,
    output logic [dbr_pkg::ID_W-1:0]      hop_id,
    output logic                          is_self,
    output logic                          used_fallback,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [dbr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dbr_pkg::ID_W-1:0]      cfg_data
);

    dbr_pkg::dbr_cmd_t    cmd;
    dbr_pkg::dbr_status_t status;

    assign cfg_ready = 1'b1;

    dbr_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    dbr_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .target_id     (target_id),
        .cmd           (cmd),
        .status        (status),
        .hop_id        (hop_id),
        .is_self       (is_self),
        .used_fallback (used_fallback),
        .done          (done)
    );

    // A result is only issued out of a working state
    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(busy))
        else $error("result issued while idle");

    // Results never come in adjacent cycles
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("two results in adjacent cycles");

    // A taken item keeps the block busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("item taken but block not busy");

    // Self routing never takes the fallback
    assert property (@(posedge clk) disable iff (!rst_n) (done && is_self) |-> !used_fallback)
        else $error("fallback flagged on self route");

endmodule
